// File: rtl/mcts_pkg.sv
package mcts_pkg;

    // Number of distinct note periods in the melody and the phase slots per period.
    localparam int NUM_PERIODS = 8;
    localparam int PHASE_SLOTS = 32;
    localparam int CLASS_W     = 3;
    localparam int PHASE_W     = 5;
    localparam int NOTE_W      = 5;
    localparam int PERIOD_W    = 5;
    localparam int COS_MAG_W   = 15;
    localparam int VOLUME_W    = 15;
    localparam int REPEAT_W    = 16;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic CFG_VOLUME  = 1'b0;
    localparam logic CFG_REPEATS = 1'b1;

    localparam logic [VOLUME_W-1:0] VOLUME_RESET  = 15'd1000;
    localparam logic [REPEAT_W-1:0] REPEATS_RESET = 16'd1000;

    // Period in samples of each period class, shortest first.
    localparam logic [PERIOD_W-1:0] CLASS_PERIOD [NUM_PERIODS] = '{
        5'd15, 5'd17, 5'd18, 5'd20, 5'd22, 5'd24, 5'd27, 5'd30
    };

    // Period class of each note of the melody. Slots past the melody use class 7, the longest period.
    localparam logic [CLASS_W-1:0] NOTE_CLASS [32] = '{
        3'd7, 3'd7, 3'd6, 3'd7, 3'd4, 3'd5, 3'd7, 3'd7,
        3'd6, 3'd7, 3'd3, 3'd4, 3'd7, 3'd7, 3'd0, 3'd2,
        3'd4, 3'd5, 3'd6, 3'd1, 3'd1, 3'd2, 3'd4, 3'd3,
        3'd4, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
    };

    // Cosine table word: sign and magnitude of the Q1.F cosine value.
    typedef struct packed {
        logic                 neg;
        logic [COS_MAG_W-1:0] mag;
    } cos_word_t;

    localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    // Fixed-point product (a * b) >> 62, used only while building the table.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Unsigned quotient by shift and subtract, used only while building the table.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Cosine or sine in Q62 for an angle in the first quadrant, by Taylor series.
    function automatic logic [63:0] trig_q62(input logic want_sin, input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] negsum;
        logic [63:0] k;
        x2     = mul_q62(x, x);
        t      = want_sin ? x : Q62_ONE;
        pos    = t;
        negsum = 64'd0;
        k      = want_sin ? 64'd2 : 64'd1;
        for (int i = 1; i <= 14; i++) begin
            t = div_u64(mul_q62(t, x2), k * (k + 64'd1));
            k = k + 64'd2;
            if (i[0]) begin
                negsum = negsum + t;
            end else begin
                pos = pos + t;
            end
        end
        return pos - negsum;
    endfunction

endpackage

// File: rtl/mcts_cos_rom.sv
module mcts_cos_rom
    import mcts_pkg::*;
#(
    parameter int COS_FRAC_BITS = 15
) (
    input  logic [CLASS_W-1:0] period_class,
    input  logic [PHASE_W-1:0] phase,
    output cos_word_t          cos_word
);

    // One row of 32 phase slots for each period class; slots past the period hold zero.
    cos_word_t rom_table [NUM_PERIODS*PHASE_SLOTS];

    for (genvar c = 0; c < NUM_PERIODS; c++) begin : g_class
        for (genvar p = 0; p < PHASE_SLOTS; p++) begin : g_phase
            localparam logic [63:0] PER   = {59'd0, CLASS_PERIOD[c]};
            localparam logic [63:0] QV    = 64'(4 * p);
            localparam logic [63:0] QUAD  = (QV / PER) & 64'd3;
            localparam logic [63:0] REM   = QV % PER;
            localparam logic [63:0] ANGLE = (HALF_PI_Q62 / PER) * REM
                                          + ((HALF_PI_Q62 % PER) * REM) / PER;
            localparam logic [63:0] TRIG  = trig_q62(QUAD[0], ANGLE);
            localparam logic [63:0] AMP   = (64'd1 << COS_FRAC_BITS) - 64'd1;
            localparam logic [63:0] MAG   = (AMP * (TRIG >> 20) + (64'd1 << 41)) >> 42;
            localparam logic        IN_PERIOD = (64'(p) < PER);
            localparam logic        NEGV  = (QUAD == 64'd1) || (QUAD == 64'd2);

            assign rom_table[c*PHASE_SLOTS + p].neg = IN_PERIOD && NEGV;
            assign rom_table[c*PHASE_SLOTS + p].mag = IN_PERIOD ? MAG[COS_MAG_W-1:0]
                                                                : '0;
        end
    end

    assign cos_word = rom_table[{period_class, phase}];

endmodule

// File: rtl/melody_cosine_tone_sequencer_top.sv
// Melody cosine tone sequencer. Every input word with tick set yields exactly one output
// word holding the next audio sample of a fixed 25-note melody, the note it belongs to,
// and a song_end flag on the last sample before the melody wraps to note 0; a word with
// tick clear is taken and yields nothing. Each note is a cosine of 15 to 30 samples per
// period, played for repeats_per_note whole periods (0 acts as 1), scaled by volume and
// truncated toward zero. The block takes one word per clock while the output is not
// stalled: the first stage looks up the cosine table and advances the note, phase and
// repeat counters, the second stage does the volume multiply; the output handshake alone
// sets the rate. Configuration is written through cfg_we, cfg_index and cfg_wdata (index
// 0 volume, index 1 repeats_per_note); the user must write it only while the block is
// idle; the block does not enforce it. Both reset to 1000; there is no clearing pass.
module melody_cosine_tone_sequencer_top
    import mcts_pkg::*;
#(
    parameter int NUM_NOTES     = 25,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_tick,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SAMPLE_W-1:0]   m_sample,
    output logic [NOTE_W-1:0]     m_note_number,
    output logic                  m_song_end
);

    localparam logic [NOTE_W:0] NOTE_COUNT = (NOTE_W+1)'(NUM_NOTES);

    // Configuration registers.
    logic [VOLUME_W-1:0] volume_reg;
    logic [REPEAT_W-1:0] repeats_reg;

    // Sequencer state.
    logic [NOTE_W-1:0]   note_pos_reg,      note_pos_next;
    logic [PHASE_W-1:0]  phase_pos_reg,     phase_pos_next;
    logic [REPEAT_W-1:0] period_repeat_reg, period_repeat_next;

    // First stage: cosine word and tags of the sample being built.
    logic                s1_valid_reg;
    cos_word_t           s1_cos_reg;
    logic [NOTE_W-1:0]   s1_note_reg;
    logic                s1_end_reg;

    // Output register.
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_sample_reg,      m_sample_next;
    logic [NOTE_W-1:0]   m_note_reg;
    logic                m_end_reg;

    logic                s1_advance;
    logic                fire;
    logic [CLASS_W-1:0]  period_class;
    logic [PERIOD_W-1:0] period;
    logic [PHASE_W-1:0]  phase_eff;
    logic [REPEAT_W-1:0] reps_eff;
    logic                last_phase;
    logic                last_repeat;
    logic                last_note;
    logic                song_end;
    cos_word_t           cos_word;
    logic [VOLUME_W+COS_MAG_W-1:0] product;
    logic [SAMPLE_W-1:0] sample_mag;

    // The output register frees the first stage whenever it is empty or being drained.
    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign fire       = s_valid && s_ready && s_tick;

    assign period_class = NOTE_CLASS[note_pos_reg];
    assign period       = CLASS_PERIOD[period_class];
    // A phase left beyond the period plays as the start of the period.
    assign phase_eff    = (phase_pos_reg >= period) ? '0 : phase_pos_reg;
    assign reps_eff     = (repeats_reg == '0) ? REPEAT_W'(1) : repeats_reg;

    assign last_phase  = ({1'b0, phase_eff} + 6'd1) >= {1'b0, period};
    assign last_repeat = ({1'b0, period_repeat_reg} + 17'd1) >= {1'b0, reps_eff};
    assign last_note   = ({1'b0, note_pos_reg} + 6'd1) >= NOTE_COUNT;
    assign song_end    = last_phase && last_repeat && last_note;

    mcts_cos_rom #(
        .COS_FRAC_BITS(COS_FRAC_BITS)
    ) u_cos_rom (
        .period_class(period_class),
        .phase       (phase_eff),
        .cos_word    (cos_word)
    );

    // Phase runs through the period, then the period repeats, then the note advances.
    always_comb begin
        note_pos_next      = note_pos_reg;
        phase_pos_next     = phase_eff;
        period_repeat_next = period_repeat_reg;
        if (!last_phase) begin
            phase_pos_next = phase_eff + PHASE_W'(1);
        end else begin
            phase_pos_next = '0;
            if (!last_repeat) begin
                period_repeat_next = period_repeat_reg + REPEAT_W'(1);
            end else begin
                period_repeat_next = '0;
                note_pos_next      = last_note ? '0 : note_pos_reg + NOTE_W'(1);
            end
        end
    end

    // Volume scaling: truncate the magnitude, then apply the sign.
    assign product    = {{COS_MAG_W{1'b0}}, volume_reg} * {{VOLUME_W{1'b0}}, s1_cos_reg.mag};
    assign sample_mag = SAMPLE_W'(product >> COS_FRAC_BITS);
    assign m_sample_next = s1_cos_reg.neg ? (SAMPLE_W'(0) - sample_mag) : sample_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg  <= VOLUME_RESET;
            repeats_reg <= REPEATS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_VOLUME:  volume_reg  <= cfg_wdata[VOLUME_W-1:0];
                CFG_REPEATS: repeats_reg <= cfg_wdata[REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_pos_reg      <= '0;
            phase_pos_reg     <= '0;
            period_repeat_reg <= '0;
        end else if (fire) begin
            note_pos_reg      <= note_pos_next;
            phase_pos_reg     <= phase_pos_next;
            period_repeat_reg <= period_repeat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= fire;
            end
            if (s1_advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            s1_cos_reg  <= cos_word;
            s1_note_reg <= note_pos_reg;
            s1_end_reg  <= song_end;
        end
        if (s1_advance && s1_valid_reg) begin
            m_sample_reg <= m_sample_next;
            m_note_reg   <= s1_note_reg;
            m_end_reg    <= s1_end_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample      = m_sample_reg;
    assign m_note_number = m_note_reg;
    assign m_song_end    = m_end_reg;

endmodule
